>>> src/drr_pkg.sv
`default_nettype none

package drr_pkg;

  // Defaults for the top-level parameters.
  localparam int NUM_CLASSES_DEF = 4;
  localparam int FIFO_DEPTH_DEF  = 64;

  // Field widths of the command and result items.
  localparam int MODE_W  = 2;
  localparam int CLASS_W = 2;
  localparam int SIZE_W  = 16;
  localparam int TAG_W   = 16;
  localparam int WAIT_W  = 9;
  localparam int DESC_W  = SIZE_W + TAG_W;

  // Deficit counters saturate at their all-ones value.
  localparam int DEF_W = 18;
  localparam logic [DEF_W-1:0] DEFICIT_MAX = '1;

  // Configuration register map.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MASK_W     = 4;
  localparam int NUM_QREGS  = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = CFG_IDX_W'(NUM_QREGS);

  localparam logic [SIZE_W-1:0] QUANTUM_RESET = SIZE_W'(1500);
  localparam logic [MASK_W-1:0] MASK_RESET    = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQUEUE = 2'd0,
    MODE_DEQUEUE = 2'd1,
    MODE_RELOAD  = 2'd2
  } drr_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_FINISH
  } drr_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CLASS_W-1:0] class_index;
    logic [SIZE_W-1:0]  pkt_len;
    logic [TAG_W-1:0]   packet_tag;
  } drr_cmd_t;

  typedef struct packed {
    logic               accepted;
    logic [CLASS_W-1:0] sent_class;
    logic [SIZE_W-1:0]  sent_size;
    logic [TAG_W-1:0]   sent_tag;
    logic [WAIT_W-1:0]  packets_waiting;
  } drr_res_t;

endpackage

`default_nettype wire

>>> src/drr_ram.sv
`default_nettype none

module drr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/deficit_round_robin_scheduler.sv
`default_nettype none

// Channel   Signals                          Direction  Carries
// -------   -------------------------------  ---------  ---------------------------------
// cmd       cmd_valid, cmd_ready, cmd        in         one operation item (drr_cmd_t)
// res       res_valid, res_ready, res        out        one result item per command
// cfg       cfg_valid, cfg_ready, cfg_index, in         register write (quantum 0..3,
//           cfg_data                                    then the class enable mask)
//
// Enqueue, reload and the unused mode do their work at the accepting edge; ST_FINISH then
// loads the result into the output register once that register is free.
// A dequeue scans the classes from class 0: an empty class needs ST_SCAN alone and
// a non-empty one ST_CHECK too, as its head descriptor comes from the synchronous memory.
// Reset (rst, synchronous) empties every FIFO and sets quanta and deficits to 1500.
// While the output is stalled one more item may run; its result then waits in pend.

module deficit_round_robin_scheduler
  import drr_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire drr_cmd_t              cmd,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output drr_res_t                   res,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(NUM_CLASSES);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int FW = PW + 1;
  localparam int RAM_DEPTH = NUM_CLASSES * FIFO_DEPTH;
  localparam int AW = $clog2(RAM_DEPTH);

  // Per-class queue bookkeeping and credit; the descriptors live in the memory.
  logic [PW-1:0]     head    [NUM_CLASSES];
  logic [PW-1:0]     tail    [NUM_CLASSES];
  logic [FW-1:0]     fill    [NUM_CLASSES];
  logic [DEF_W-1:0]  deficit [NUM_CLASSES];
  logic [SIZE_W-1:0] quantum [NUM_CLASSES];
  logic [MASK_W-1:0] enable_mask;
  logic [WAIT_W-1:0] total;

  drr_state_t state, state_next;

  // Scan position during a dequeue; it reaches NUM_CLASSES when nothing was sent.
  logic [CW:0]   sc;
  logic [CW-1:0] idx;
  logic          scan_done;

  // Result of the item in flight, handed to the output register at the end.
  drr_res_t pend;

  logic              accept;
  logic              enq_ok;
  logic [CW-1:0]     eidx;
  logic              fits;
  logic [DEF_W:0]    credit_sum;
  logic [DEF_W-1:0]  credit_sat;
  logic [SIZE_W-1:0] head_size;
  logic [TAG_W-1:0]  head_tag;
  logic              load_res;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [DESC_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [DESC_W-1:0] ram_rd_data;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  drr_ram #(
    .WIDTH(DESC_W),
    .DEPTH(RAM_DEPTH)
  ) u_desc_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign cfg_ready = 1'b1;

  assign idx       = sc[CW-1:0];
  assign scan_done = (sc == (CW+1)'(NUM_CLASSES));
  assign eidx      = CW'(cmd.class_index);

  // An enqueue needs an existing, enabled class with room left in its FIFO.
  assign enq_ok = (cmd.mode == MODE_ENQUEUE) &&
                  (int'(cmd.class_index) < NUM_CLASSES) &&
                  enable_mask[cmd.class_index] &&
                  (fill[eidx] < FW'(FIFO_DEPTH));

  assign head_size  = ram_rd_data[DESC_W-1:TAG_W];
  assign head_tag   = ram_rd_data[TAG_W-1:0];
  assign fits       = ({{(DEF_W-SIZE_W){1'b0}}, head_size} <= deficit[idx]);
  assign credit_sum = {1'b0, deficit[idx]} + (DEF_W+1)'(quantum[idx]);
  assign credit_sat = credit_sum[DEF_W] ? DEFICIT_MAX : credit_sum[DEF_W-1:0];

  // Descriptor writes come from enqueues at accept time; reads from the scan.
  assign ram_wr_addr = AW'(int'(eidx) * FIFO_DEPTH + int'(tail[eidx]));
  assign ram_wr_data = {cmd.pkt_len, cmd.packet_tag};
  assign ram_rd_addr = AW'(int'(idx) * FIFO_DEPTH + int'(head[idx]));

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    accept     = 1'b0;
    ram_wr_en  = 1'b0;
    ram_rd_en  = 1'b0;
    load_res   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          accept    = 1'b1;
          ram_wr_en = enq_ok;
          if (cmd.mode == MODE_DEQUEUE) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end else if (fill[idx] != '0) begin
          ram_rd_en  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fits) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (!res_valid || res_ready) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]    <= '0;
        tail[c]    <= '0;
        fill[c]    <= '0;
        deficit[c] <= DEF_W'(QUANTUM_RESET);
        quantum[c] <= (c < NUM_QREGS) ? QUANTUM_RESET : '0;
      end
      enable_mask <= MASK_RESET;
      total       <= '0;
      res_valid   <= 1'b0;
    end else begin
      // Users must send register writes only with no item in flight; this is not checked.
      if (cfg_valid) begin
        if (int'(cfg_index) < NUM_QREGS) begin
          if (int'(cfg_index) < NUM_CLASSES) begin
            quantum[CW'(cfg_index)] <= cfg_data;
          end
        end else if (cfg_index == CFG_ENABLE_MASK) begin
          enable_mask <= cfg_data[MASK_W-1:0];
        end
      end

      if (accept) begin
        pend <= '{accepted: enq_ok, sent_class: '0, sent_size: '0, sent_tag: '0,
                  packets_waiting: '0};
        sc   <= '0;
        case (cmd.mode)
          MODE_ENQUEUE: begin
            if (enq_ok) begin
              tail[eidx] <= next_slot(tail[eidx]);
              fill[eidx] <= fill[eidx] + 1'b1;
              total      <= total + 1'b1;
            end
          end
          MODE_RELOAD: begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
              deficit[c] <= DEF_W'(quantum[c]);
            end
          end
          default: begin
          end
        endcase
      end

      // An empty class is skipped without touching its deficit.
      if (state == ST_SCAN && !scan_done && fill[idx] == '0) begin
        sc <= sc + 1'b1;
      end

      // The head descriptor is on the memory output; send it or top up the credit.
      if (state == ST_CHECK) begin
        if (fits) begin
          deficit[idx] <= deficit[idx] - DEF_W'(head_size);
          head[idx]    <= next_slot(head[idx]);
          fill[idx]    <= fill[idx] - 1'b1;
          total        <= total - 1'b1;
          pend         <= '{accepted: 1'b1, sent_class: CLASS_W'(idx), sent_size: head_size,
                            sent_tag: head_tag, packets_waiting: '0};
        end else begin
          deficit[idx] <= credit_sat;
          sc           <= sc + 1'b1;
        end
      end

      if (load_res) begin
        res       <= '{accepted: pend.accepted, sent_class: pend.sent_class,
                       sent_size: pend.sent_size, sent_tag: pend.sent_tag,
                       packets_waiting: total};
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/drr_schedule_checker.sv
// Watches the command, configuration and result channels of the scheduler. It keeps
// its own copy of the per-class queues, deficits, quanta and enable mask, predicts
// one result item for every accepted command, and compares each delivered result
// with the oldest prediction.
module drr_schedule_checker
  import drr_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  input  wire logic                  cmd_ready,
  input  wire drr_cmd_t              cmd,
  input  wire logic                  res_valid,
  input  wire logic                  res_ready,
  input  wire drr_res_t              res,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         outstanding,
  output int                         mismatches,
  output int                         results_checked,
  output int                         packets_sent,
  output int                         enqueues_refused
);

  logic [DESC_W-1:0] queue_mem [NUM_CLASSES][FIFO_DEPTH];
  int                queue_head [NUM_CLASSES];
  int                queue_fill [NUM_CLASSES];
  logic [DEF_W-1:0]  credit [NUM_CLASSES];
  logic [SIZE_W-1:0] quanta [NUM_CLASSES];
  logic [MASK_W-1:0] enable_mask;
  drr_res_t          predicted_results [$];

  // Applies one command to the shadow state and returns the result it should produce.
  function automatic drr_res_t schedule_step(input drr_cmd_t c);
    drr_res_t         r;
    logic [DESC_W-1:0] head;
    logic [DEF_W:0]   grown;
    logic             sent;
    int               total;
    r = '0;
    sent = 1'b0;
    total = 0;
    case (c.mode)
      MODE_ENQUEUE: begin
        if (c.class_index < NUM_CLASSES && enable_mask[c.class_index] &&
            queue_fill[c.class_index] < FIFO_DEPTH) begin
          queue_mem[c.class_index][(queue_head[c.class_index] + queue_fill[c.class_index]) %
                                   FIFO_DEPTH] = {c.pkt_len, c.packet_tag};
          queue_fill[c.class_index]++;
          r.accepted = 1'b1;
        end else begin
          enqueues_refused++;
        end
      end
      MODE_DEQUEUE: begin
        // The scan always starts at class 0; classes passed over earn their quantum.
        for (int k = 0; k < NUM_CLASSES; k++) begin
          if (!sent && queue_fill[k] != 0) begin
            head = queue_mem[k][queue_head[k]];
            if (credit[k] >= head[DESC_W-1:TAG_W]) begin
              credit[k] = credit[k] - head[DESC_W-1:TAG_W];
              queue_head[k] = (queue_head[k] + 1) % FIFO_DEPTH;
              queue_fill[k]--;
              sent = 1'b1;
              r.accepted = 1'b1;
              r.sent_class = CLASS_W'(k);
              r.sent_size = head[DESC_W-1:TAG_W];
              r.sent_tag = head[TAG_W-1:0];
              packets_sent++;
            end else begin
              grown = {1'b0, credit[k]} + quanta[k];
              credit[k] = (grown > DEFICIT_MAX) ? DEFICIT_MAX : grown[DEF_W-1:0];
            end
          end
        end
      end
      MODE_RELOAD: begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
          credit[k] = DEF_W'(quanta[k]);
        end
      end
      default: begin
      end
    endcase
    for (int k = 0; k < NUM_CLASSES; k++) begin
      total += queue_fill[k];
    end
    r.packets_waiting = WAIT_W'(total);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    drr_res_t want;
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        queue_head[k] = 0;
        queue_fill[k] = 0;
        credit[k] = DEF_W'(QUANTUM_RESET);
        quanta[k] = (k < NUM_QREGS) ? QUANTUM_RESET : '0;
      end
      enable_mask = MASK_RESET;
      predicted_results.delete();
      mismatches = 0;
      results_checked = 0;
      packets_sent = 0;
      enqueues_refused = 0;
    end else begin
      // Results are retired before new predictions are queued, so a stray result
      // cannot be matched against a command accepted at the same edge.
      if (res_valid && res_ready) begin
        results_checked++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result with no prediction waiting, expected none, actual %h",
                   $time, res);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("accepted", 32'(want.accepted), 32'(res.accepted));
          compare_field("sent_class", 32'(want.sent_class), 32'(res.sent_class));
          compare_field("sent_size", 32'(want.sent_size), 32'(res.sent_size));
          compare_field("sent_tag", 32'(want.sent_tag), 32'(res.sent_tag));
          compare_field("packets_waiting", 32'(want.packets_waiting),
                        32'(res.packets_waiting));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < NUM_QREGS) begin
          if (cfg_index < NUM_CLASSES) quanta[cfg_index] = cfg_data;
        end else if (cfg_index == CFG_ENABLE_MASK) begin
          enable_mask = cfg_data[MASK_W-1:0];
        end
      end
      if (cmd_valid && cmd_ready) begin
        predicted_results.insert(predicted_results.size(), schedule_step(cmd));
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

>>> tb/tb_deficit_round_robin_scheduler.sv
// Top of the scheduler testbench. It makes the clock and the single reset, drives the
// command and configuration channels, plays the part of the result receiver, and
// gives the verdict. All prediction and comparison lives in the checker beside the
// block; this module only reads its counters.
module tb_deficit_round_robin_scheduler;
  import drr_pkg::*;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int IDLE_PERCENT  = 19;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 170;
  localparam int NUM_PHASES    = 5;
  localparam int BURST_START   = 40;
  // A burst a little longer than one class queue, so the queue overflows.
  localparam int BURST_LEN     = FIFO_DEPTH_DEF + 4;
  // Longest dequeue scan plus the output register, with some margin.
  localparam int SETTLE_CYCLES = 2 * NUM_CLASSES_DEF + 8;

  // The block leaves the fourth mode code unused; it must change nothing.
  localparam logic [MODE_W-1:0]    MODE_UNUSED        = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_ENABLE_MASK + 1'b1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_ready;
  drr_cmd_t              cmd = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  drr_res_t              res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus-to-receiver controls: a stretch with no idling, and requests for a long
  // hold-off of the result channel.
  logic no_idle = 1'b0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;

  int cycle_count = 0;
  int commands_sent = 0;

  int outstanding;
  int mismatches;
  int results_checked;
  int packets_sent;
  int enqueues_refused;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  deficit_round_robin_scheduler #(
    .NUM_CLASSES(NUM_CLASSES_DEF),
    .FIFO_DEPTH (FIFO_DEPTH_DEF)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  drr_schedule_checker #(
    .NUM_CLASSES(NUM_CLASSES_DEF),
    .FIFO_DEPTH (FIFO_DEPTH_DEF)
  ) schedule_check (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .results_checked (results_checked),
    .packets_sent    (packets_sent),
    .enqueues_refused(enqueues_refused)
  );

  // Receiver side. Normally it stalls at random; when the stimulus asks for a hold-off
  // it keeps ready low for a long count of its own, so the block backs up and has to
  // refuse new command items.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one command item, possibly after a few idle cycles, and returns at the edge
  // where it was taken. Valid is left high; the next call or quiesce decides its fate,
  // so valid never gets two updates in one time step.
  task automatic send_cmd(input logic [MODE_W-1:0] mode, input int cls, input int size,
                          input int tag);
    drr_cmd_t item;
    item.mode = mode;
    item.class_index = CLASS_W'(cls);
    item.pkt_len = SIZE_W'(size);
    item.packet_tag = TAG_W'(tag);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    commands_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drops both request channels and waits until every predicted result has arrived.
  // The first wait is unconditional: the checker's count lags the edge by one step.
  task automatic quiesce;
    cmd_valid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Sizes are mostly small so that packets flow, with some large ones that have to
  // wait several rounds for credit, and the two extremes now and then.
  function automatic int pick_packet_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return $urandom_range(0, 1600);
    else if (roll < 80) return $urandom_range(1601, 8000);
    else if (roll < 95) return $urandom_range(0, 16'hFFFF);
    else return roll[0] ? 16'hFFFF : 0;
  endfunction

  initial begin
    int roll;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening with the reset quanta of 1500. A dequeue with nothing queued,
    // a reload, and the unused mode all report accepted low and empty sent fields.
    send_cmd(MODE_DEQUEUE, 0, 0, 0);
    send_cmd(MODE_RELOAD, 3, 16'hFFFF, 16'hFFFF);
    send_cmd(MODE_UNUSED, 2, 16'h1234, 16'h5678);
    // One packet per class at the size extremes, plus an exact fit (class 2) and a
    // packet one byte over the credit (class 3) that must be passed over once.
    send_cmd(MODE_ENQUEUE, 0, 0, 0);
    send_cmd(MODE_ENQUEUE, 1, 16'hFFFF, 16'hFFFF);
    send_cmd(MODE_ENQUEUE, 2, 1500, 16'hA5A5);
    send_cmd(MODE_ENQUEUE, 3, 1501, 16'h5A5A);
    send_cmd(MODE_ENQUEUE, 0, 1, 16'h0001);
    // These dequeues drain class 0, send class 2 while class 1 earns credit, then
    // produce a round where nobody sends before class 3 finally goes.
    repeat (8) send_cmd(MODE_DEQUEUE, 0, 0, 0);

    // Disable classes 1 and 3; the upper data bits of the mask write are ignored.
    // Writes to the unmapped indexes must not disturb anything.
    quiesce;
    write_reg(CFG_ENABLE_MASK, 16'hFFF5);
    for (int k = CFG_FIRST_UNMAPPED; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), 16'hFFFF);
    end
    quiesce;
    send_cmd(MODE_ENQUEUE, 1, 100, 16'h0101);
    send_cmd(MODE_ENQUEUE, 3, 100, 16'h0303);
    send_cmd(MODE_ENQUEUE, 2, 100, 16'h0202);
    send_cmd(MODE_ENQUEUE, 0, 100, 16'h0000);
    repeat (2) send_cmd(MODE_DEQUEUE, 0, 0, 0);

    // Random phases, each under its own quantum and mask setting. Every phase holds a
    // burst of enqueues to one class that overflows its queue if the class is enabled.
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce;
      case (p)
        0: begin
          for (int k = 0; k < NUM_QREGS; k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(1, 4000)));
          end
          write_reg(CFG_ENABLE_MASK, 16'h000F);
        end
        1: begin
          for (int k = 0; k < NUM_QREGS; k++) write_reg(CFG_IDX_W'(k), 16'hFFFF);
          write_reg(CFG_ENABLE_MASK, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        end
        2: begin
          // Zero quantum starves classes 0 and 2 once their credit runs out; class 1
          // crawls, class 3 gets the largest quantum.
          write_reg(CFG_IDX_W'(0), 16'h0000);
          write_reg(CFG_IDX_W'(1), 16'h0001);
          write_reg(CFG_IDX_W'(2), 16'h0000);
          write_reg(CFG_IDX_W'(3), 16'hFFFF);
          write_reg(CFG_ENABLE_MASK, 16'h000F);
        end
        3: begin
          for (int k = 0; k < NUM_QREGS; k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
          end
          write_reg(CFG_ENABLE_MASK, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
          for (int k = CFG_FIRST_UNMAPPED; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
          end
        end
        default: begin
          for (int k = 0; k < NUM_QREGS; k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(100, 3000)));
          end
          write_reg(CFG_ENABLE_MASK, 16'h000F);
        end
      endcase
      quiesce;
      // The first phase runs with neither side idling.
      no_idle <= (p == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In the second phase the receiver stops for a long while and the sender keeps
        // pushing, which fills the block and stalls its command input.
        if (p == 1 && n == BURST_START + BURST_LEN) hold_requests <= hold_requests + 1;
        if (n >= BURST_START && n < BURST_START + BURST_LEN) begin
          send_cmd(MODE_ENQUEUE, p % NUM_CLASSES_DEF, pick_packet_size(),
                   $urandom_range(0, 16'hFFFF));
        end else begin
          roll = $urandom_range(99);
          if (roll < 46) begin
            send_cmd(MODE_ENQUEUE, $urandom_range(0, 3), pick_packet_size(),
                     $urandom_range(0, 16'hFFFF));
          end else if (roll < 89) begin
            send_cmd(MODE_DEQUEUE, $urandom_range(0, 3), $urandom_range(0, 16'hFFFF),
                     $urandom_range(0, 16'hFFFF));
          end else if (roll < 96) begin
            send_cmd(MODE_RELOAD, $urandom_range(0, 3), $urandom_range(0, 16'hFFFF),
                     $urandom_range(0, 16'hFFFF));
          end else begin
            send_cmd(MODE_UNUSED, $urandom_range(0, 3), $urandom_range(0, 16'hFFFF),
                     $urandom_range(0, 16'hFFFF));
          end
        end
      end
    end

    quiesce;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d command items over %0d quantum and mask settings in %0d cycles.",
             commands_sent, NUM_PHASES + 2, cycle_count);
    $display("Checked %0d results: %0d packets scheduled out, %0d enqueues refused.",
             results_checked, packets_sent, enqueues_refused);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> deficit_round_robin_scheduler.f
src/drr_pkg.sv
src/drr_ram.sv
src/deficit_round_robin_scheduler.sv
tb/drr_schedule_checker.sv
tb/tb_deficit_round_robin_scheduler.sv
